[rtl/iee_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and codes for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;

    // controller -> datapath
    typedef struct packed {
        logic       clear;
        logic       accum_digit;
        logic [3:0] digit;
        logic       push_accum;
        logic       push_op;
        logic [1:0] op;
        logic       reduce_start;
        logic       set_err;
        logic [1:0] err;
    } iee_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       digit_seen;
        logic [1:0] operand_count;
        logic [1:0] operator_count;
        logic [1:0] top_op;
        logic [1:0] error_code;
        logic       busy;
    } iee_stat_t;

endpackage
`default_nettype wire

[rtl/iee_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iee_datapath
// Operand/operator stacks, digit accumulator, and reduction unit with a
// one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module iee_datapath import iee_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  iee_cmd_t          cmd,
    output iee_stat_t         stat,
    output logic [VALUE_WIDTH-1:0] bottom
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    typedef logic [VALUE_WIDTH-1:0] val_t;

    val_t       accum_reg, accum_next;
    logic       seen_reg, seen_next;
    val_t       opnd_reg [3];
    val_t       opnd_next [3];
    logic [1:0] ocnt_reg, ocnt_next;
    logic [1:0] oper_reg [2];
    logic [1:0] oper_next [2];
    logic [1:0] pcnt_reg, pcnt_next;
    logic [1:0] err_reg, err_next;
    // divider
    logic       div_reg, div_next;
    logic [CW-1:0] step_reg, step_next;
    val_t       quo_reg, quo_next, rem_reg, rem_next, dvs_reg, dvs_next;
    logic       neg_reg, neg_next;

    val_t a, b, res, ma, mb;
    logic [1:0] op;
    logic [VALUE_WIDTH:0] trial;
    logic push_res;
    logic [3:0] d4;

    always_comb begin
        b  = opnd_reg[ocnt_reg - 2'd1];
        a  = opnd_reg[ocnt_reg - 2'd2];
        op = oper_reg[pcnt_reg[1]];
        ma = a[VALUE_WIDTH-1] ? -a : a;
        mb = b[VALUE_WIDTH-1] ? -b : b;
        trial = {rem_reg, quo_reg[VALUE_WIDTH-1]} - {1'b0, dvs_reg};
    end

    always_comb begin
        accum_next = accum_reg;
        seen_next  = seen_reg;
        opnd_next  = opnd_reg;
        ocnt_next  = ocnt_reg;
        oper_next  = oper_reg;
        pcnt_next  = pcnt_reg;
        err_next   = err_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        push_res   = 1'b0;
        res        = '0;
        d4         = cmd.digit;
        if (cmd.accum_digit) begin
            accum_next = VALUE_WIDTH'(accum_reg * VALUE_WIDTH'(10)) + VALUE_WIDTH'(d4);
            seen_next  = 1'b1;
        end
        if (cmd.push_accum) begin
            if (ocnt_reg < 2'd3) begin
                opnd_next[ocnt_reg] = accum_reg;
                ocnt_next = ocnt_reg + 2'd1;
            end
            accum_next = '0;
            seen_next  = 1'b0;
        end
        if (cmd.push_op) begin
            oper_next[pcnt_reg[0]] = cmd.op;
            pcnt_next = pcnt_reg + 2'd1;
        end
        if (cmd.set_err && err_reg == ST_OK) err_next = cmd.err;
        if (cmd.reduce_start) begin
            if (pcnt_reg == 2'd0 || ocnt_reg < 2'd2) begin
                if (err_reg == ST_OK) err_next = ST_FORMAT;
            end else begin
                case (op)
                    OP_ADD: begin res = a + b; push_res = 1'b1; end
                    OP_SUB: begin res = a - b; push_res = 1'b1; end
                    OP_MUL: begin res = VALUE_WIDTH'(a * b); push_res = 1'b1; end
                    default: begin
                        if (b == '0) begin
                            if (err_reg == ST_OK) err_next = ST_DIV0;
                            push_res = 1'b1;
                        end else begin
                            div_next  = 1'b1;
                            step_next = '0;
                            quo_next  = ma;
                            rem_next  = '0;
                            dvs_next  = mb;
                            neg_next  = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                        end
                    end
                endcase
            end
        end
        if (div_reg) begin
            if (!trial[VALUE_WIDTH]) begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[VALUE_WIDTH-2:0], quo_reg[VALUE_WIDTH-1]};
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            step_next = step_reg + CW'(1);
            if (step_reg == CW'(VALUE_WIDTH)) begin
                div_next = 1'b0;
                push_res = 1'b1;
                res = neg_reg ? -quo_reg : quo_reg;
                rem_next = rem_reg;
                quo_next = quo_reg;
            end
        end
        if (push_res) begin
            opnd_next[ocnt_reg - 2'd2] = res;
            ocnt_next = ocnt_reg - 2'd1;
            pcnt_next = pcnt_reg - 2'd1;
        end
        if (cmd.clear) begin
            accum_next = '0;
            seen_next  = 1'b0;
            ocnt_next  = '0;
            pcnt_next  = '0;
            err_next   = ST_OK;
            div_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg <= opnd_next;
        oper_reg <= oper_next;
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        if (!aresetn) begin
            accum_reg <= '0;
            seen_reg  <= 1'b0;
            ocnt_reg  <= '0;
            pcnt_reg  <= '0;
            err_reg   <= ST_OK;
            div_reg   <= 1'b0;
        end else begin
            accum_reg <= accum_next;
            seen_reg  <= seen_next;
            ocnt_reg  <= ocnt_next;
            pcnt_reg  <= pcnt_next;
            err_reg   <= err_next;
            div_reg   <= div_next;
        end
    end

    assign stat.digit_seen     = seen_reg;
    assign stat.operand_count  = ocnt_reg;
    assign stat.operator_count = pcnt_reg;
    assign stat.top_op         = oper_reg[pcnt_reg[1] ? 1'b1 : 1'b0];
    assign stat.error_code     = err_reg;
    assign stat.busy           = div_reg;
    assign bottom              = opnd_reg[0];
endmodule
`default_nettype wire

[rtl/iee_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iee_controller
// Sequencer: decodes characters, drives reductions, emits the result.
// ----------------------------------------------------------------------------
module iee_controller import iee_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] in_char,
    input  wire        in_last,
    input  iee_stat_t  stat,
    output iee_cmd_t   cmd,
    output logic       out_load
);
    typedef enum logic [2:0] {
        S_IDLE, S_ONE_ISSUE, S_ALL_ISSUE, S_WAIT, S_PUSH, S_FIN_CHECK, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic       all_reg, all_next;
    logic       fin_reg, fin_next;
    logic       tail_reg, tail_next;
    logic [1:0] op_reg, op_next;

    logic is_digit, is_op;
    logic [1:0] dec_op;

    always_comb begin
        is_digit = in_char >= CH_ZERO && in_char <= CH_NINE;
        is_op    = 1'b1;
        dec_op   = OP_ADD;
        case (in_char)
            CH_ADD:  dec_op = OP_ADD;
            CH_SUB:  dec_op = OP_SUB;
            CH_MUL:  dec_op = OP_MUL;
            CH_DIV:  dec_op = OP_DIV;
            default: is_op = 1'b0;
        endcase
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        all_next   = all_reg;
        fin_next   = fin_reg;
        tail_next  = tail_reg;
        op_next    = op_reg;
        cmd        = '0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    fin_next = in_last;
                    if (stat.error_code != ST_OK) begin
                        if (in_last) state_next = S_DONE;
                    end else if (is_digit) begin
                        cmd.accum_digit = 1'b1;
                        cmd.digit = in_char[3:0];
                        if (in_last) begin
                            state_next = S_FIN_CHECK;
                        end
                    end else if (is_op) begin
                        if (!stat.digit_seen) begin
                            cmd.set_err = 1'b1;
                            cmd.err = ST_FORMAT;
                            if (in_last) state_next = S_DONE;
                        end else begin
                            cmd.push_accum = 1'b1;
                            op_next = dec_op;
                            all_next = !dec_op[1];
                            tail_next = 1'b0;
                            state_next = dec_op[1] ? S_ONE_ISSUE : S_ALL_ISSUE;
                        end
                    end else begin
                        cmd.set_err = 1'b1;
                        cmd.err = ST_FORMAT;
                        if (in_last) state_next = S_DONE;
                    end
                end
            end
            S_FIN_CHECK: begin
                cmd.push_accum = 1'b1;
                all_next = 1'b1;
                tail_next = 1'b1;
                op_next  = OP_ADD;
                state_next = S_ALL_ISSUE;
            end
            S_ONE_ISSUE: begin
                if (stat.operator_count != 2'd0 && stat.top_op[1]) begin
                    cmd.reduce_start = 1'b1;
                    state_next = S_WAIT;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_ALL_ISSUE: begin
                if (stat.operator_count != 2'd0 && stat.error_code == ST_OK) begin
                    cmd.reduce_start = 1'b1;
                    state_next = S_WAIT;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_WAIT: begin
                if (!stat.busy) state_next = all_reg ? S_ALL_ISSUE : S_PUSH;
            end
            S_PUSH: begin
                if (tail_reg) begin
                    if (stat.error_code == ST_OK && stat.operand_count != 2'd1) begin
                        cmd.set_err = 1'b1;
                        cmd.err = ST_FORMAT;
                    end
                    state_next = S_DONE;
                end else begin
                    if (stat.error_code == ST_OK) begin
                        if (stat.operator_count < 2'd2) begin
                            cmd.push_op = 1'b1;
                            cmd.op = op_reg;
                        end else begin
                            cmd.set_err = 1'b1;
                            cmd.err = ST_FORMAT;
                        end
                    end
                    if (fin_reg) begin
                        cmd.set_err = 1'b1;
                        cmd.err = ST_FORMAT;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                out_load  = 1'b1;
                cmd.clear = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            all_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            op_reg    <= OP_ADD;
        end else begin
            state_reg <= state_next;
            all_reg   <= all_next;
            fin_reg   <= fin_next;
            tail_reg  <= tail_next;
            op_reg    <= op_next;
        end
    end
endmodule
`default_nettype wire

[rtl/infix_expression_evaluator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Streaming infix evaluator: one ASCII character per transaction, result on
// the character flagged tlast.
// ----------------------------------------------------------------------------
// Digit: accumulated on acceptance. Operator: * or / first reduces one pending * or /,
// + or - reduces every pending operator, then the operator is pushed; a division runs
// the divider. Final character: the pending reductions run, then S_DONE loads m_tvalid.
// The output register holds a result while the next expression streams in.
// Synchronous active-low reset clears the control state and the stack counts.
module infix_expression_evaluator_unit import iee_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] char_in
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [33:32] status
);
    iee_cmd_t  cmd;
    iee_stat_t stat;
    logic [VALUE_WIDTH-1:0] bottom;
    logic out_load, ctl_ready;
    logic        mv_reg;
    logic [31:0] val_reg;
    logic [1:0]  st_reg;
    logic [31:0] bot32;

    iee_controller u_ctl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid && s_tready),
        .in_ready(ctl_ready), .in_char(s_tdata), .in_last(s_tlast), .stat(stat),
        .cmd(cmd), .out_load(out_load)
    );

    iee_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .bottom(bottom)
    );

    // a finished result waits for the output register to drain
    assign s_tready = ctl_ready && !(s_tlast && mv_reg && !m_tready);

    always_comb begin
        bot32 = '0;
        for (int i = 0; i < 32; i++) begin
            if (i < VALUE_WIDTH) bot32[i] = bottom[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            val_reg <= (stat.error_code == ST_OK) ? bot32 : 32'd0;
            st_reg  <= stat.error_code;
        end
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (out_load) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, st_reg, val_reg};

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:32] != 2'd3) else $error("bad status");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:32] != ST_OK |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero value on error");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_tready) else $error("accept during divide");
endmodule
`default_nettype wire
